// ===== design/tcpu_pkg.sv =====
// Shared types, opcodes and helper functions of the tiny 8-bit processor core.
`timescale 1ns / 1ps
`default_nettype none

package tcpu_pkg;

  // Storage sizes
  localparam int MEM_DEPTH = 1024;
  localparam int REG_COUNT = 8;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int REG_AW    = $clog2(REG_COUNT);

  // Flag bit positions
  localparam int FLAG_Z_BIT = 0;
  localparam int FLAG_C_BIT = 1;
  localparam int FLAG_N_BIT = 2;

  // Opcodes
  localparam logic [7:0] OP_LDI   = 8'h10;
  localparam logic [7:0] OP_MOV   = 8'h11;
  localparam logic [7:0] OP_ADD   = 8'h20;
  localparam logic [7:0] OP_SUB   = 8'h21;
  localparam logic [7:0] OP_INC   = 8'h22;
  localparam logic [7:0] OP_DEC   = 8'h23;
  localparam logic [7:0] OP_JMP   = 8'h30;
  localparam logic [7:0] OP_JZ    = 8'h31;
  localparam logic [7:0] OP_JNZ   = 8'h32;
  localparam logic [7:0] OP_JN    = 8'h33;
  localparam logic [7:0] OP_JC    = 8'h34;
  localparam logic [7:0] OP_JNC   = 8'h35;
  localparam logic [7:0] OP_PUSH  = 8'h40;
  localparam logic [7:0] OP_POP   = 8'h41;
  localparam logic [7:0] OP_CALL  = 8'h42;
  localparam logic [7:0] OP_RET   = 8'h43;
  localparam logic [7:0] OP_STORE = 8'h50;
  localparam logic [7:0] OP_LOAD  = 8'h51;
  localparam logic [7:0] OP_PRINT = 8'h60;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [7:0] res;
    logic       carry;
    logic       zero;
    logic       neg;
  } alu_res_t;

  // Single-port memory request
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // Register file write port
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [7:0]        data;
  } rf_wr_t;

  // Number of operand bytes that follow an opcode
  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op) inside
      OP_LDI, OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JC, OP_JNC, OP_CALL: n = 2'd2;
      OP_MOV, OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_PUSH, OP_POP, OP_PRINT: n = 2'd1;
      OP_STORE, OP_LOAD: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Build a wrapped address from a little-endian byte pair
  function automatic logic [ADDR_W-1:0] mk_addr(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] w;
    w = {hi, lo};
    return w[ADDR_W-1:0];
  endfunction

  // High byte of an address
  function automatic logic [7:0] hi_byte(input logic [ADDR_W-1:0] a);
    logic [15:0] w;
    w = 16'(a);
    return w[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== design/tiny_8bit_cpu_core.sv =====
// Top level of the tiny 8-bit processor core: command sequencer and result register.
//
// Input channel (in_valid_i / in_stall_o) carries a command: write a memory
// byte, read a memory byte, or execute one instruction at the program counter.
// Each command yields exactly one result on the output channel
// (out_valid_o / out_stall_i): print flag, printed or read byte, halted flag,
// program counter and flags after the command.
// One command is worked on at a time. A memory write passes through S_MWR
// from transfer to result, a read through S_MRD and S_MRDW. An instruction
// issues the opcode fetch, captures each fetched byte through the single memory
// port, runs the execute steps that it needs (S_OPA, S_OPB, S_OPC) for register
// file, adder and stack work, then loads the result.
// in_stall_o drops again in the cycle after the result is loaded.
// After reset the block runs a clearing pass over every memory address that
// zeroes the memory and the register file; in_stall_o stays high meanwhile.
// While the receiver stalls, the result register holds; the next command is
// still taken and worked on, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module tiny_8bit_cpu_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic [tcpu_pkg::ADDR_W-1:0] mem_addr_i,
  input  logic [7:0]                  mem_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        print_valid_o,
  output logic [7:0]                  out_value_o,
  output logic                        halted_o,
  output logic [tcpu_pkg::ADDR_W-1:0] program_counter_o,
  output logic [2:0]                  flag_bits_o
);

  localparam int AW = tcpu_pkg::ADDR_W;
  localparam int RW = tcpu_pkg::REG_AW;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_MWR   = 12'b0000_0000_0100,
    S_MRD   = 12'b0000_0000_1000,
    S_MRDW  = 12'b0000_0001_0000,
    S_FETCH = 12'b0000_0010_0000,
    S_CAPT  = 12'b0000_0100_0000,
    S_OPA   = 12'b0000_1000_0000,
    S_OPB   = 12'b0001_0000_0000,
    S_OPC   = 12'b0010_0000_0000,
    S_DONE  = 12'b0100_0000_0000,
    S_SPARE = 12'b1000_0000_0000
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [7:0]     wdata_q, wdata_d;
  logic [AW-1:0]  pc_q, pc_d;
  logic [AW-1:0]  sp_q, sp_d;
  logic [2:0]     flags_q, flags_d;
  logic           run_q, run_d;
  logic [7:0]     op_q, op_d;
  logic [7:0]     b1_q, b1_d;
  logic [7:0]     b2_q, b2_d;
  logic [7:0]     b3_q, b3_d;
  logic [1:0]     idx_q, idx_d;
  logic [7:0]     opa_q, opa_d;
  logic [7:0]     val_q, val_d;
  logic           prn_q, prn_d;

  logic           out_valid_q, out_valid_d;
  logic           out_pv_q, out_pv_d;
  logic [7:0]     out_val_q, out_val_d;
  logic           out_halt_q, out_halt_d;
  logic [AW-1:0]  out_pc_q, out_pc_d;
  logic [2:0]     out_flags_q, out_flags_d;

  tcpu_pkg::mem_req_t  mem_req;
  logic [7:0]          mem_rdata;
  tcpu_pkg::rf_wr_t    rf_wr;
  logic [RW-1:0]       rf_raddr;
  logic [7:0]          rf_rdata;
  logic [7:0]          alu_a, alu_b;
  tcpu_pkg::alu_op_e   alu_op;
  tcpu_pkg::alu_res_t  alu_res;

  logic                in_xfer, out_xfer;
  logic [7:0]          op_now;
  logic [RW-1:0]       r_sel, x_sel, y_sel;
  logic [AW-1:0]       jmp_addr, data_addr;
  logic                jmp_taken;

  tcpu_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tcpu_rf u_rf (
    .clk_i   (clk_i),
    .wr_i    (rf_wr),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  tcpu_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  // Handshakes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  // Operand fields
  assign r_sel     = b1_q[RW-1:0];
  assign x_sel     = b1_q[4 +: RW];
  assign y_sel     = b1_q[RW-1:0];
  assign jmp_addr  = tcpu_pkg::mk_addr(b1_q, b2_q);
  assign data_addr = tcpu_pkg::mk_addr(b2_q, b3_q);
  assign op_now    = (idx_q == 2'd0) ? mem_rdata : op_q;

  // Evaluate the branch condition
  always_comb begin
    case (op_q) inside
      tcpu_pkg::OP_JMP: jmp_taken = 1'b1;
      tcpu_pkg::OP_JZ:  jmp_taken = flags_q[tcpu_pkg::FLAG_Z_BIT];
      tcpu_pkg::OP_JNZ: jmp_taken = !flags_q[tcpu_pkg::FLAG_Z_BIT];
      tcpu_pkg::OP_JN:  jmp_taken = flags_q[tcpu_pkg::FLAG_N_BIT];
      tcpu_pkg::OP_JC:  jmp_taken = flags_q[tcpu_pkg::FLAG_C_BIT];
      tcpu_pkg::OP_JNC: jmp_taken = !flags_q[tcpu_pkg::FLAG_C_BIT];
      default:          jmp_taken = 1'b0;
    endcase
  end

  // Sequence one command
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    wdata_d  = wdata_q;
    pc_d     = pc_q;
    sp_d     = sp_q;
    flags_d  = flags_q;
    run_d    = run_q;
    op_d     = op_q;
    b1_d     = b1_q;
    b2_d     = b2_q;
    b3_d     = b3_q;
    idx_d    = idx_q;
    opa_d    = opa_q;
    val_d    = val_q;
    prn_d    = prn_q;

    mem_req       = '0;
    mem_req.addr  = pc_q;
    rf_wr         = '0;
    rf_raddr      = r_sel;
    alu_a         = opa_q;
    alu_b         = rf_rdata;
    alu_op        = tcpu_pkg::ALU_ADD;

    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    out_pv_d    = out_pv_q;
    out_val_d   = out_val_q;
    out_halt_d  = out_halt_q;
    out_pc_d    = out_pc_q;
    out_flags_d = out_flags_q;

    unique case (state_q)
      // Zero memory and registers, one entry a cycle
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_q;
        mem_req.wdata = 8'd0;
        rf_wr.we      = 1'b1;
        rf_wr.addr    = clr_q[RW-1:0];
        rf_wr.data    = 8'd0;
        clr_d         = clr_q + AW'(1);
        if (clr_q == AW'(tcpu_pkg::MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take a command
      S_IDLE: begin
        if (in_xfer) begin
          addr_d  = mem_addr_i;
          wdata_d = mem_wdata_i;
          val_d   = 8'd0;
          prn_d   = 1'b0;
          unique case (command_i)
            tcpu_pkg::CMD_WRITE: state_d = S_MWR;
            tcpu_pkg::CMD_READ:  state_d = S_MRD;
            tcpu_pkg::CMD_EXEC:  state_d = run_q ? S_FETCH : S_DONE;
            default:             state_d = S_DONE;
          endcase
        end
      end

      S_MWR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = addr_q;
        mem_req.wdata = wdata_q;
        state_d       = S_DONE;
      end

      S_MRD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = addr_q;
        state_d      = S_MRDW;
      end

      S_MRDW: begin
        val_d   = mem_rdata;
        state_d = S_DONE;
      end

      // Issue the opcode fetch
      S_FETCH: begin
        mem_req.re = 1'b1;
        pc_d       = pc_q + AW'(1);
        idx_d      = 2'd0;
        state_d    = S_CAPT;
      end

      // Capture a byte and fetch the next one while more are needed
      S_CAPT: begin
        case (idx_q)
          2'd0:    op_d = mem_rdata;
          2'd1:    b1_d = mem_rdata;
          2'd2:    b2_d = mem_rdata;
          default: b3_d = mem_rdata;
        endcase
        if (idx_q < tcpu_pkg::op_len(op_now)) begin
          mem_req.re = 1'b1;
          pc_d       = pc_q + AW'(1);
          idx_d      = idx_q + 2'd1;
        end else begin
          state_d = S_OPA;
        end
      end

      // First execute step: register read or write, branch, halt, stack or memory access
      S_OPA: begin
        state_d = S_OPB;
        unique case (op_q) inside
          tcpu_pkg::OP_LDI: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = r_sel;
            rf_wr.data = b2_q;
            state_d    = S_DONE;
          end
          tcpu_pkg::OP_MOV: rf_raddr = y_sel;
          tcpu_pkg::OP_ADD, tcpu_pkg::OP_SUB: rf_raddr = x_sel;
          tcpu_pkg::OP_INC, tcpu_pkg::OP_DEC, tcpu_pkg::OP_PUSH,
          tcpu_pkg::OP_STORE, tcpu_pkg::OP_PRINT: rf_raddr = r_sel;
          tcpu_pkg::OP_JMP, tcpu_pkg::OP_JZ, tcpu_pkg::OP_JNZ,
          tcpu_pkg::OP_JN, tcpu_pkg::OP_JC, tcpu_pkg::OP_JNC: begin
            if (jmp_taken) begin
              pc_d = jmp_addr;
            end
            state_d = S_DONE;
          end
          tcpu_pkg::OP_POP, tcpu_pkg::OP_RET: begin
            sp_d         = sp_q + AW'(1);
            mem_req.re   = 1'b1;
            mem_req.addr = sp_q + AW'(1);
          end
          tcpu_pkg::OP_CALL: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = sp_q;
            mem_req.wdata = pc_q[7:0];
            sp_d          = sp_q - AW'(1);
          end
          tcpu_pkg::OP_LOAD: begin
            mem_req.re   = 1'b1;
            mem_req.addr = data_addr;
          end
          tcpu_pkg::OP_HALT: begin
            run_d   = 1'b0;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end

      // Second execute step: use the read data, or push the high return byte and jump for a call
      S_OPB: begin
        state_d = S_DONE;
        unique case (op_q) inside
          tcpu_pkg::OP_MOV: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = x_sel;
            rf_wr.data = rf_rdata;
          end
          tcpu_pkg::OP_ADD, tcpu_pkg::OP_SUB: begin
            opa_d    = rf_rdata;
            rf_raddr = y_sel;
            state_d  = S_OPC;
          end
          tcpu_pkg::OP_INC, tcpu_pkg::OP_DEC: begin
            alu_a      = rf_rdata;
            alu_b      = (op_q == tcpu_pkg::OP_INC) ? 8'h01 : 8'hFF;
            rf_wr.we   = 1'b1;
            rf_wr.addr = r_sel;
            rf_wr.data = alu_res.res;
            flags_d[tcpu_pkg::FLAG_Z_BIT] = alu_res.zero;
            flags_d[tcpu_pkg::FLAG_N_BIT] = alu_res.neg;
            if (op_q == tcpu_pkg::OP_INC) begin
              flags_d[tcpu_pkg::FLAG_C_BIT] = alu_res.carry;
            end
          end
          tcpu_pkg::OP_PUSH: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = sp_q;
            mem_req.wdata = rf_rdata;
            sp_d          = sp_q - AW'(1);
          end
          tcpu_pkg::OP_POP, tcpu_pkg::OP_LOAD: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = r_sel;
            rf_wr.data = mem_rdata;
          end
          tcpu_pkg::OP_CALL: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = sp_q;
            mem_req.wdata = tcpu_pkg::hi_byte(pc_q);
            sp_d          = sp_q - AW'(1);
            pc_d          = jmp_addr;
          end
          tcpu_pkg::OP_RET: begin
            opa_d        = mem_rdata;
            sp_d         = sp_q + AW'(1);
            mem_req.re   = 1'b1;
            mem_req.addr = sp_q + AW'(1);
            state_d      = S_OPC;
          end
          tcpu_pkg::OP_STORE: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = data_addr;
            mem_req.wdata = rf_rdata;
          end
          tcpu_pkg::OP_PRINT: begin
            val_d = rf_rdata;
            prn_d = 1'b1;
          end
          default: state_d = S_DONE;
        endcase
      end

      // Third execute step: two-operand arithmetic or return address
      S_OPC: begin
        state_d = S_DONE;
        if (op_q == tcpu_pkg::OP_RET) begin
          pc_d = tcpu_pkg::mk_addr(mem_rdata, opa_q);
        end else begin
          alu_op     = (op_q == tcpu_pkg::OP_SUB) ? tcpu_pkg::ALU_SUB : tcpu_pkg::ALU_ADD;
          rf_wr.we   = 1'b1;
          rf_wr.addr = x_sel;
          rf_wr.data = alu_res.res;
          flags_d[tcpu_pkg::FLAG_Z_BIT] = alu_res.zero;
          flags_d[tcpu_pkg::FLAG_N_BIT] = alu_res.neg;
          if (op_q == tcpu_pkg::OP_ADD) begin
            flags_d[tcpu_pkg::FLAG_C_BIT] = alu_res.carry;
          end
        end
      end

      // Load the result once the output register is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_pv_d    = prn_q;
          out_val_d   = val_q;
          out_halt_d  = !run_q;
          out_pc_d    = pc_q;
          out_flags_d = flags_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      sp_q        <= AW'(tcpu_pkg::MEM_DEPTH - 1);
      flags_q     <= 3'd0;
      run_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      flags_q     <= flags_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    wdata_q     <= wdata_d;
    op_q        <= op_d;
    b1_q        <= b1_d;
    b2_q        <= b2_d;
    b3_q        <= b3_d;
    idx_q       <= idx_d;
    opa_q       <= opa_d;
    val_q       <= val_d;
    prn_q       <= prn_d;
    out_pv_q    <= out_pv_d;
    out_val_q   <= out_val_d;
    out_halt_q  <= out_halt_d;
    out_pc_q    <= out_pc_d;
    out_flags_q <= out_flags_d;
  end

  assign out_valid_o       = out_valid_q;
  assign print_valid_o     = out_pv_q;
  assign out_value_o       = out_val_q;
  assign halted_o          = out_halt_q;
  assign program_counter_o = out_pc_q;
  assign flag_bits_o       = out_flags_q;

  // A halted core never reports a print
  a_no_print_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && print_valid_o && halted_o))
    else $error("print reported by a halted core");

  // Halt is sticky
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |=> !run_q)
    else $error("core left the halted state");

  // A taken command always leaves the idle state
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a transfer");

  // Program counter moves only while an instruction runs
  a_pc_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE || state_q == S_CLEAR) |=> $stable(pc_q))
    else $error("program counter changed outside execution");

endmodule

`default_nettype wire

// ===== design/tcpu_mem.sv =====
// Program and data memory: one port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcpu_mem (
  input  logic               clk_i,
  input  tcpu_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [tcpu_pkg::MEM_DEPTH];
  logic [7:0] rdata_q;

  // Write or read at the one shared address
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/tcpu_rf.sv =====
// General register file: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcpu_rf (
  input  logic                        clk_i,
  input  tcpu_pkg::rf_wr_t            wr_i,
  input  logic [tcpu_pkg::REG_AW-1:0] raddr_i,
  output logic [7:0]                  rdata_o
);

  logic [7:0] regs_q [tcpu_pkg::REG_COUNT];
  logic [7:0] rdata_q;

  // Write when enabled; read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      regs_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= regs_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/tcpu_alu.sv =====
// Shared 8-bit adder for add, sub, inc and dec with flag results.
`timescale 1ns / 1ps
`default_nettype none

module tcpu_alu (
  input  logic [7:0]         a_i,
  input  logic [7:0]         b_i,
  input  tcpu_pkg::alu_op_e  op_i,
  output tcpu_pkg::alu_res_t res_o
);

  logic [8:0] sum;

  // Subtract as add of the inverted operand plus one
  always_comb begin
    case (op_i)
      tcpu_pkg::ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      tcpu_pkg::ALU_SUB: sum = {1'b0, a_i} + {1'b0, ~b_i} + 9'd1;
      default:           sum = {1'b0, a_i};
    endcase
  end

  assign res_o.res   = sum[7:0];
  assign res_o.carry = sum[8];
  assign res_o.zero  = (sum[7:0] == 8'd0);
  assign res_o.neg   = sum[7];

endmodule

`default_nettype wire

// ===== tb/sv/tiny_8bit_cpu_core_tb.sv =====
// Self-checking testbench for the tiny 8-bit processor core: random programs checked by a scoreboard.
`timescale 1ns / 1ps

module tiny_8bit_cpu_core_tb;
  import tcpu_pkg::*;

  // Command value that the core has no use for
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int DIRECTED_ITEMS = 23;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int CALM_TAIL      = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              print_valid;
    logic [7:0]        value;
    logic              halted;
    logic [ADDR_W-1:0] pc;
    logic [2:0]        flags;
  } cpu_result_t;

  // Architectural shadow of the core plus the queue of results it owes
  class cpu_scoreboard;
    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        regs [REG_COUNT];
    logic [ADDR_W-1:0] sp;
    logic [ADDR_W-1:0] pc;
    logic [2:0]        flags;
    bit                running;
    cpu_result_t       expected_q [$];
    int unsigned       errors;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      foreach (regs[i]) regs[i] = 8'h00;
      sp      = ADDR_W'(MEM_DEPTH - 1);
      pc      = '0;
      flags   = '0;
      running = 1'b1;
      errors  = 0;
    endfunction

    function logic [REG_AW-1:0] reg_sel(logic [7:0] b);
      return b[REG_AW-1:0];
    endfunction

    function logic [7:0] fetch_byte();
      logic [7:0] b;
      b  = mem[pc];
      pc = pc + 1'b1;
      return b;
    endfunction

    // Little-endian address operand, wrapped to the memory size
    function logic [ADDR_W-1:0] fetch_target();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = fetch_byte();
      hi = fetch_byte();
      return ADDR_W'({hi, lo});
    endfunction

    function void update_zn(logic [7:0] v);
      flags[FLAG_Z_BIT] = (v == 8'h00);
      flags[FLAG_N_BIT] = v[7];
    endfunction

    function void push_byte(logic [7:0] v);
      mem[sp] = v;
      sp      = sp - 1'b1;
    endfunction

    function logic [7:0] pop_byte();
      sp = sp + 1'b1;
      return mem[sp];
    endfunction

    function void branch(logic cond);
      logic [ADDR_W-1:0] target;
      target = fetch_target();
      if (cond) pc = target;
    endfunction

    // Fetch and execute one instruction at pc
    function void step_cpu(output logic printed, output logic [7:0] shown);
      logic [7:0]        op;
      logic [7:0]        b;
      logic [7:0]        lo;
      logic [7:0]        hi;
      logic [REG_AW-1:0] x;
      logic [REG_AW-1:0] y;
      logic [8:0]        wide;
      logic [ADDR_W-1:0] target;
      printed = 1'b0;
      shown   = 8'h00;
      op      = fetch_byte();
      case (op)
        OP_LDI: begin
          x       = reg_sel(fetch_byte());
          regs[x] = fetch_byte();
        end
        OP_MOV: begin
          b = fetch_byte();
          regs[reg_sel(b >> 4)] = regs[reg_sel(b)];
        end
        OP_ADD: begin
          b    = fetch_byte();
          x    = reg_sel(b >> 4);
          y    = reg_sel(b);
          wide = {1'b0, regs[x]} + {1'b0, regs[y]};
          flags[FLAG_C_BIT] = wide[8];
          regs[x] = wide[7:0];
          update_zn(regs[x]);
        end
        OP_SUB: begin
          // carry is left alone
          b       = fetch_byte();
          x       = reg_sel(b >> 4);
          y       = reg_sel(b);
          regs[x] = regs[x] - regs[y];
          update_zn(regs[x]);
        end
        OP_INC: begin
          x    = reg_sel(fetch_byte());
          wide = {1'b0, regs[x]} + 9'd1;
          flags[FLAG_C_BIT] = wide[8];
          regs[x] = wide[7:0];
          update_zn(regs[x]);
        end
        OP_DEC: begin
          x       = reg_sel(fetch_byte());
          regs[x] = regs[x] - 8'd1;
          update_zn(regs[x]);
        end
        OP_JMP: branch(1'b1);
        OP_JZ:  branch(flags[FLAG_Z_BIT]);
        OP_JNZ: branch(!flags[FLAG_Z_BIT]);
        OP_JN:  branch(flags[FLAG_N_BIT]);
        OP_JC:  branch(flags[FLAG_C_BIT]);
        OP_JNC: branch(!flags[FLAG_C_BIT]);
        OP_PUSH: begin
          x = reg_sel(fetch_byte());
          push_byte(regs[x]);
        end
        OP_POP: begin
          x       = reg_sel(fetch_byte());
          regs[x] = pop_byte();
        end
        OP_CALL: begin
          target = fetch_target();
          push_byte(pc[7:0]);
          push_byte(8'(pc >> 8));
          pc = target;
        end
        OP_RET: begin
          hi = pop_byte();
          lo = pop_byte();
          pc = ADDR_W'({hi, lo});
        end
        OP_STORE: begin
          x           = reg_sel(fetch_byte());
          target      = fetch_target();
          mem[target] = regs[x];
        end
        OP_LOAD: begin
          x       = reg_sel(fetch_byte());
          target  = fetch_target();
          regs[x] = mem[target];
        end
        OP_PRINT: begin
          x       = reg_sel(fetch_byte());
          printed = 1'b1;
          shown   = regs[x];
        end
        OP_HALT: running = 1'b0;
        default: ;
      endcase
    endfunction

    // Apply one accepted command and queue the result it owes
    function void note_transfer(logic [1:0] cmd, logic [ADDR_W-1:0] addr, logic [7:0] wdata);
      cpu_result_t r;
      logic        printed;
      logic [7:0]  shown;
      printed = 1'b0;
      shown   = 8'h00;
      if (cmd == CMD_WRITE) begin
        mem[addr] = wdata;
      end else if (cmd == CMD_EXEC) begin
        if (running) step_cpu(printed, shown);
      end else if (cmd == CMD_READ) begin
        shown = mem[addr];
      end
      r.print_valid = printed;
      r.value       = shown;
      r.halted      = !running;
      r.pc          = pc;
      r.flags       = flags;
      expected_q.push_back(r);
    endfunction

    // Compare one delivered result against the oldest expectation
    function void check_result(cpu_result_t got);
      cpu_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: value %02h pc %03h", $time,
                   got.value, got.pc);
        return;
      end
      want = expected_q.pop_front();
      if (got.print_valid !== want.print_valid || got.value !== want.value ||
          got.halted !== want.halted || got.pc !== want.pc || got.flags !== want.flags) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: mismatch (exp/got) print %0b/%0b value %02h/%02h ",
                    "halted %0b/%0b pc %03h/%03h flags %03b/%03b"}, $time,
                   want.print_valid, got.print_valid, want.value, got.value,
                   want.halted, got.halted, want.pc, got.pc, want.flags, got.flags);
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [1:0]        command   = 2'd0;
  logic [ADDR_W-1:0] mem_addr  = '0;
  logic [7:0]        mem_wdata = 8'h00;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              print_valid;
  logic [7:0]        out_value;
  logic              halted;
  logic [ADDR_W-1:0] program_counter;
  logic [2:0]        flag_bits;

  cpu_scoreboard sb;
  int            idle_mode  = 1;
  bit            hold_req   = 1'b0;
  int            items_sent = 0;

  logic [7:0] opcode_pool [19] = '{OP_LDI, OP_MOV, OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_JMP,
                                   OP_JZ, OP_JNZ, OP_JN, OP_JC, OP_JNC, OP_PUSH, OP_POP,
                                   OP_CALL, OP_RET, OP_STORE, OP_LOAD, OP_PRINT};

  // Opening program: load 0x80 through an out-of-range index, print, add to overflow,
  // decrement below zero, print, then an unknown opcode
  logic [7:0] boot_code [12] = '{OP_LDI, 8'hFF, 8'h80, OP_PRINT, 8'h0F, OP_ADD, 8'h77,
                                 OP_DEC, 8'hFF, OP_PRINT, 8'h07, 8'h00};

  tiny_8bit_cpu_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (command),
    .mem_addr_i        (mem_addr),
    .mem_wdata_i       (mem_wdata),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .print_valid_o     (print_valid),
    .out_value_o       (out_value),
    .halted_o          (halted),
    .program_counter_o (program_counter),
    .flag_bits_o       (flag_bits)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
  endfunction

  // Register values lean toward the carry and sign boundaries
  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h01;
      default: return rand_byte();
    endcase
  endfunction

  // Targets lean toward the wrap point and the live stack bytes
  function automatic logic [ADDR_W-1:0] pick_target();
    case ($urandom_range(0, 7))
      0:       return ADDR_W'(MEM_DEPTH - 1 - $urandom_range(0, 3));
      1:       return ADDR_W'($urandom_range(0, 3));
      2, 3:    return sb.sp + ADDR_W'($urandom_range(1, 4));
      default: return rand_addr();
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] op;
    bit         known;
    do begin
      op    = rand_byte();
      known = (op == OP_HALT);
      foreach (opcode_pool[i]) if (opcode_pool[i] == op) known = 1'b1;
    end while (known);
    return op;
  endfunction

  // Address operand with random bits above the memory size
  function automatic void push_target(ref logic [7:0] code [$], input logic [ADDR_W-1:0] t);
    logic [15:0] w;
    w = 16'($urandom_range(0, 65535));
    w[ADDR_W-1:0] = t;
    code.push_back(w[7:0]);
    code.push_back(w[15:8]);
  endfunction

  // Append one random instruction, halt excluded
  function automatic void add_instr(ref logic [7:0] code [$]);
    logic [7:0] op;
    op = opcode_pool[$urandom_range(0, 18)];
    if ($urandom_range(0, 19) == 0) op = pick_unknown();
    code.push_back(op);
    case (op)
      OP_LDI: begin
        code.push_back(rand_byte());
        code.push_back(pick_value());
      end
      OP_MOV, OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_PUSH, OP_POP, OP_PRINT:
        code.push_back(rand_byte());
      OP_JMP, OP_JZ, OP_JNZ, OP_JN, OP_JC, OP_JNC, OP_CALL:
        push_target(code, pick_target());
      OP_STORE, OP_LOAD: begin
        code.push_back(rand_byte());
        push_target(code, pick_target());
      end
      default: ;
    endcase
  endfunction

  // Offer one command and hold it until the core takes the transfer
  task automatic send_item(logic [1:0] cmd, logic [ADDR_W-1:0] addr, logic [7:0] data);
    if (idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 5 : 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    mem_addr  <= addr;
    mem_wdata <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(cmd, addr, data);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Execute at pc; patch a stray halt first so the core keeps running
  task automatic exec_next();
    if (sb.mem[sb.pc] == OP_HALT) send_item(CMD_WRITE, sb.pc, pick_unknown());
    send_item(CMD_EXEC, rand_addr(), rand_byte());
  endtask

  // Load a few instructions at pc and run them
  task automatic run_program();
    logic [7:0]        code [$];
    logic [ADDR_W-1:0] base;
    int                n;
    n    = $urandom_range(1, 4);
    base = sb.pc;
    repeat (n) add_instr(code);
    foreach (code[i]) send_item(CMD_WRITE, base + ADDR_W'(i), code[i]);
    repeat (n) exec_next();
  endtask

  // Stimulus
  initial begin
    int  roll;
    int  mode_until;
    bit  pressure_done;
    mode_until    = 150;
    pressure_done = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: memory edges, unused command, opening program
    send_item(CMD_READ, ADDR_W'(MEM_DEPTH - 1), 8'h00);
    send_item(CMD_WRITE, ADDR_W'(MEM_DEPTH - 1), 8'hFF);
    send_item(CMD_READ, ADDR_W'(MEM_DEPTH - 1), 8'h00);
    send_item(CMD_UNUSED, ADDR_W'(MEM_DEPTH - 1), 8'hFF);
    foreach (boot_code[i]) send_item(CMD_WRITE, ADDR_W'(i), boot_code[i]);
    repeat (6) exec_next();
    send_item(CMD_READ, ADDR_W'(3), 8'h00);

    // Random: mostly short programs, the rest loose memory traffic and junk execution
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (items_sent > DIRECTED_ITEMS + RANDOM_ITEMS - CALM_TAIL) begin
        idle_mode = 0;
      end else if (items_sent >= mode_until) begin
        idle_mode  = $urandom_range(0, 2);
        mode_until = items_sent + 150;
      end
      if (!pressure_done && items_sent > RANDOM_ITEMS / 2) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      roll = $urandom_range(0, 19);
      if (roll < 12) begin
        run_program();
      end else if (roll < 14) begin
        send_item(CMD_WRITE, rand_addr(), rand_byte());
      end else if (roll < 16) begin
        send_item(CMD_READ, ($urandom_range(0, 1) == 0) ? pick_target() : rand_addr(),
                  rand_byte());
      end else if (roll == 16) begin
        send_item(CMD_UNUSED, rand_addr(), rand_byte());
      end else if (roll == 17) begin
        exec_next();
      end else begin
        send_item(CMD_WRITE, sb.pc, pick_unknown());
        exec_next();
      end
    end

    // Halt, then show that execution stops while memory access still works
    send_item(CMD_WRITE, sb.pc, OP_HALT);
    repeat (3) send_item(CMD_EXEC, rand_addr(), rand_byte());
    send_item(CMD_WRITE, '0, 8'hA5);
    send_item(CMD_READ, '0, rand_byte());
    send_item(CMD_UNUSED, rand_addr(), rand_byte());

    // Drain outstanding results
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 5 : 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({print_valid, out_value, halted, program_counter, flag_bits});
  end

  // Watchdog: end the run when neither channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
